### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the frame table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FTLE_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

`define FTLE_ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define FTLE_ASSERT(name, clk, rst, prop)

`define FTLE_ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

### rtl/ftle_pkg.sv
// ----------------------------------------------------------------------------
// ftle_pkg
// Shared widths, codes and structs of the frame table.
// ----------------------------------------------------------------------------
package ftle_pkg;

  localparam int FRAME_W = 20;
  localparam int PAGE_W  = 32;
  localparam int TICK_W  = 32;

  localparam logic [1:0] ACT_ALLOC  = 2'd0;
  localparam logic [1:0] ACT_FREE   = 2'd1;
  localparam logic [1:0] ACT_ACCESS = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {
    M_FIRST = 2'd0,
    M_EVICT = 2'd1,
    M_FIND  = 2'd2
  } mode_t;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  page;
    logic [TICK_W-1:0]  tick;
  } entry_t;

  typedef struct packed {
    logic set_valid;
    logic clr_valid;
    logic we_frame;
    logic we_page;
    logic we_tick;
    logic we_rank;
  } wr_ctl_t;

  typedef struct packed {
    logic cand_ok;
    logic first_only;
    logic use_tick;
    logic found;
  } cmp_ctl_t;

endpackage

### rtl/ftle_store.sv
// ----------------------------------------------------------------------------
// ftle_store
// Entry storage: valid flops plus frame, page, tick and rank memories with
// one registered read port and one write port.
// ----------------------------------------------------------------------------
module ftle_store
  import ftle_pkg::*;
#(
  parameter int FRAMES = 64,
  parameter int AW     = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  output logic [AW-1:0] rd_rank,
  input  wr_ctl_t       wr,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] wr_rank
);

  logic [FRAMES-1:0]  valid;
  logic [FRAME_W-1:0] mem_frame [FRAMES];
  logic [PAGE_W-1:0]  mem_page  [FRAMES];
  logic [TICK_W-1:0]  mem_tick  [FRAMES];
  logic [AW-1:0]      mem_rank  [FRAMES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.set_valid) begin
      valid[wr_addr] <= 1'b1;
    end else if (wr.clr_valid) begin
      valid[wr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we_frame) mem_frame[wr_addr] <= wr_data.frame;
    if (wr.we_page)  mem_page[wr_addr]  <= wr_data.page;
    if (wr.we_tick)  mem_tick[wr_addr]  <= wr_data.tick;
    if (wr.we_rank)  mem_rank[wr_addr]  <= wr_rank;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data.valid <= valid[rd_addr];
      rd_data.frame <= mem_frame[rd_addr];
      rd_data.page  <= mem_page[rd_addr];
      rd_data.tick  <= mem_tick[rd_addr];
      rd_rank       <= mem_rank[rd_addr];
    end
  end

endmodule

### rtl/ftle_cmp.sv
// ----------------------------------------------------------------------------
// ftle_cmp
// Shared candidate compare: tick then list rank, list rank alone, or first-hit only.
// ----------------------------------------------------------------------------
module ftle_cmp
  import ftle_pkg::*;
#(
  parameter int AW = 6
) (
  input  cmp_ctl_t          ctl,
  input  logic [TICK_W-1:0] cand_tick,
  input  logic [TICK_W-1:0] best_tick,
  input  logic [AW-1:0]     cand_rank,
  input  logic [AW-1:0]     best_rank,
  output logic              take
);

  logic tick_lt;
  logic tick_eq;
  logic rank_lt;

  always_comb begin
    tick_lt = ctl.use_tick && (cand_tick < best_tick);
    tick_eq = !ctl.use_tick || (cand_tick == best_tick);
    rank_lt = cand_rank < best_rank;
    take    = ctl.cand_ok &&
              (!ctl.found || (!ctl.first_only && (tick_lt || (tick_eq && rank_lt))));
  end

endmodule

### rtl/frame_table_lru_evict_core.sv
// ----------------------------------------------------------------------------
// frame_table_lru_evict_core
// Frame table with least-recently-used eviction by access tick.
// ----------------------------------------------------------------------------
// Input beats (action, page_id, frame_num, frame_given, now_tick) are taken
// on in_valid & in_ready; exactly one result beat (granted_frame, evicted,
// victim_page, status) follows on out_valid & out_ready.
// One beat is worked at a time; in_ready is low until its result is latched.
// Each pass reads one table entry per cycle through the store read port and
// the shared compare unit. Passes per beat:
//   allocate with frame, access report:  one search pass
//   evict, free:  search pass, then rank pass
//   full table, empty table, unused code: no pass
// The result register lets the next beat be accepted while the previous
// result waits; a stalled receiver holds the following beat in its final
// state until the output register frees up.
// Synchronous reset empties the table (valid flops cleared, count zero);
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frame_table_lru_evict_core
  import ftle_pkg::*;
#(
  parameter int FRAMES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [PAGE_W-1:0]  page_id,
  input  logic [FRAME_W-1:0] frame_num,
  input  logic               frame_given,
  input  logic [TICK_W-1:0]  now_tick,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FRAME_W-1:0] granted_frame,
  output logic               evicted,
  output logic [PAGE_W-1:0]  victim_page,
  output logic [1:0]         status
);

  localparam int AW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_EVAL  = 6'b000100,
    S_GAP   = 6'b001000,
    S_WRITE = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t             state;
  mode_t              mode;
  logic [1:0]         op_act;
  logic [PAGE_W-1:0]  op_page;
  logic [FRAME_W-1:0] op_frame;
  logic [TICK_W-1:0]  op_tick;

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_m1;
  logic [CW-1:0]      iss;
  logic               chk_vld;
  logic [AW-1:0]      chk_idx;
  logic               last;

  logic               found;
  logic [AW-1:0]      b_idx;
  logic [TICK_W-1:0]  b_tick;
  logic [AW-1:0]      b_rank;
  logic [FRAME_W-1:0] b_frame;
  logic [PAGE_W-1:0]  b_page;
  logic [AW-1:0]      gap_r;

  logic [FRAME_W-1:0] res_granted;
  logic               res_evicted;
  logic [PAGE_W-1:0]  res_victim;
  logic [1:0]         res_status;

  logic               rd_en;
  entry_t             rd_q;
  logic [AW-1:0]      rd_rank;
  wr_ctl_t            wr;
  logic [AW-1:0]      wr_addr;
  entry_t             wr_data;
  logic [AW-1:0]      wr_rank;

  cmp_ctl_t           cmp_ctl;
  logic [TICK_W-1:0]  cmp_cand_tick;
  logic [TICK_W-1:0]  cmp_best_tick;
  logic [AW-1:0]      cmp_cand_rank;
  logic [AW-1:0]      cmp_best_rank;
  logic               take;

  ftle_store #(
    .FRAMES (FRAMES),
    .AW     (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (iss[AW-1:0]),
    .rd_data (rd_q),
    .rd_rank (rd_rank),
    .wr      (wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .wr_rank (wr_rank)
  );

  ftle_cmp #(
    .AW (AW)
  ) u_cmp (
    .ctl       (cmp_ctl),
    .cand_tick (cmp_cand_tick),
    .best_tick (cmp_best_tick),
    .cand_rank (cmp_cand_rank),
    .best_rank (cmp_best_rank),
    .take      (take)
  );

  assign in_ready = (state == S_IDLE);
  assign rd_en    = ((state == S_SCAN) || (state == S_GAP)) && (iss < CW'(FRAMES));
  assign last     = chk_vld && (chk_idx == AW'(FRAMES - 1));
  assign count_m1 = count - 1'b1;

  // compare unit operand select; the rank pass reuses it as gap_r < rank
  always_comb begin
    cmp_ctl       = '0;
    cmp_cand_tick = rd_q.tick;
    cmp_best_tick = b_tick;
    cmp_cand_rank = rd_rank;
    cmp_best_rank = b_rank;
    if (state == S_GAP) begin
      cmp_ctl.cand_ok = chk_vld && rd_q.valid;
      cmp_ctl.found   = 1'b1;
      cmp_best_tick   = rd_q.tick;
      cmp_cand_rank   = gap_r;
      cmp_best_rank   = rd_rank;
    end else if (state == S_SCAN) begin
      cmp_ctl.found      = found;
      cmp_ctl.first_only = (mode == M_FIRST);
      cmp_ctl.use_tick   = (mode == M_EVICT);
      case (mode)
        M_FIRST: cmp_ctl.cand_ok = chk_vld && !rd_q.valid;
        M_EVICT: cmp_ctl.cand_ok = chk_vld && rd_q.valid;
        M_FIND:  cmp_ctl.cand_ok = chk_vld && rd_q.valid && (rd_q.frame == op_frame);
        default: cmp_ctl.cand_ok = 1'b0;
      endcase
    end
  end

  always_comb begin
    wr            = '0;
    wr_addr       = b_idx;
    wr_data.valid = 1'b1;
    wr_data.frame = op_frame;
    wr_data.page  = op_page;
    wr_data.tick  = op_tick;
    wr_rank       = count[AW-1:0];
    if (state == S_GAP && take) begin
      wr.we_rank = 1'b1;
      wr_addr    = chk_idx;
      wr_rank    = rd_rank - 1'b1;
    end else if (state == S_WRITE) begin
      case (mode)
        M_FIRST: begin
          wr.set_valid = 1'b1;
          wr.we_frame  = 1'b1;
          wr.we_page   = 1'b1;
          wr.we_tick   = 1'b1;
          wr.we_rank   = 1'b1;
        end
        M_EVICT: begin
          wr.we_page = 1'b1;
          wr.we_tick = 1'b1;
          wr.we_rank = 1'b1;
          wr_rank    = count_m1[AW-1:0];
        end
        M_FIND: begin
          if (op_act == ACT_FREE) begin
            wr.clr_valid = 1'b1;
          end else begin
            wr.we_tick = 1'b1;
          end
        end
        default: wr = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chk_vld   <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      chk_vld <= rd_en;
      chk_idx <= iss[AW-1:0];
      if (rd_en) iss <= iss + 1'b1;

      if (state == S_SCAN && take) begin
        found   <= 1'b1;
        b_idx   <= chk_idx;
        b_tick  <= rd_q.tick;
        b_rank  <= rd_rank;
        b_frame <= rd_q.frame;
        b_page  <= rd_q.page;
      end

      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_act      <= action;
            op_page     <= page_id;
            op_frame    <= frame_num;
            op_tick     <= now_tick;
            res_granted <= '0;
            res_evicted <= 1'b0;
            res_victim  <= '0;
            found       <= 1'b0;
            iss         <= '0;
            case (action)
              ACT_ALLOC: begin
                if (frame_given) begin
                  if (count >= CW'(FRAMES)) begin
                    res_status <= ST_FULL;
                    state      <= S_FIN;
                  end else begin
                    res_status <= ST_OK;
                    mode       <= M_FIRST;
                    state      <= S_SCAN;
                  end
                end else if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_FIN;
                end else begin
                  res_status <= ST_OK;
                  mode       <= M_EVICT;
                  state      <= S_SCAN;
                end
              end
              ACT_FREE, ACT_ACCESS: begin
                res_status <= ST_OK;
                mode       <= M_FIND;
                state      <= S_SCAN;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (last) state <= S_EVAL;
        end
        S_EVAL: begin
          iss <= '0;
          case (mode)
            M_FIRST: begin
              if (found) begin
                state <= S_WRITE;
              end else begin
                res_status <= ST_FULL;
                state      <= S_FIN;
              end
            end
            M_EVICT: begin
              if (found) begin
                res_granted <= b_frame;
                res_evicted <= 1'b1;
                res_victim  <= b_page;
                gap_r       <= b_rank;
                state       <= S_GAP;
              end else begin
                res_status <= ST_EMPTY;
                state      <= S_FIN;
              end
            end
            M_FIND: begin
              if (!found) begin
                res_status <= ST_NOTFOUND;
                state      <= S_FIN;
              end else if (op_act == ACT_FREE) begin
                gap_r <= b_rank;
                state <= S_GAP;
              end else begin
                state <= S_WRITE;
              end
            end
            default: state <= S_FIN;
          endcase
        end
        S_GAP: begin
          if (last) state <= S_WRITE;
        end
        S_WRITE: begin
          if (mode == M_FIRST) begin
            count       <= count + 1'b1;
            res_granted <= op_frame;
          end else if (mode == M_FIND && op_act == ACT_FREE) begin
            count <= count_m1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            granted_frame <= res_granted;
            evicted       <= res_evicted;
            victim_page   <= res_victim;
            status        <= res_status;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FTLE_ASSERT(a_count_bound, clk, rst, count <= CW'(FRAMES))
  `FTLE_ASSERT(a_victim_zero, clk, rst, out_valid && !evicted |-> victim_page == '0)
  `FTLE_ASSERT(a_evict_ok, clk, rst, out_valid && evicted |-> status == ST_OK)
  `FTLE_ASSERT_NEVER(a_idle_write, clk, rst, (state == S_IDLE) && (wr != '0))
  `FTLE_ASSERT(a_count_step, clk, rst, !$past(rst) && count != $past(count) |-> $past(state) == S_WRITE)

endmodule

### tb/frame_table_lru_evict_core_test.sv
// ----------------------------------------------------------------------------
// frame_table_lru_evict_core_test
// Self-checking bench for the LRU frame table: a local copy of the table
// predicts every result beat, random stalls on both channels, one long
// output hold-off that backs the block up, and a watchdog.
// ----------------------------------------------------------------------------
module frame_table_lru_evict_core_test;
  import ftle_pkg::*;

  localparam int FRAMES = 64;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 2 * FRAMES + 40;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]         action;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic               given;
    logic [TICK_W-1:0]  tick;
  } beat_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               evicted;
    logic [PAGE_W-1:0]  victim;
    logic [1:0]         status;
  } grant_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         action = ACT_ALLOC;
  logic [PAGE_W-1:0]  page_id = '0;
  logic [FRAME_W-1:0] frame_num = '0;
  logic               frame_given = 1'b0;
  logic [TICK_W-1:0]  now_tick = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FRAME_W-1:0] granted_frame;
  logic               evicted;
  logic [PAGE_W-1:0]  victim_page;
  logic [1:0]         status;

  // local copy of the frame table
  logic               tbl_valid [FRAMES];
  logic [FRAME_W-1:0] tbl_frame [FRAMES];
  logic [PAGE_W-1:0]  tbl_page  [FRAMES];
  logic [TICK_W-1:0]  tbl_tick  [FRAMES];
  int unsigned        tbl_rank  [FRAMES];
  int unsigned        tbl_count;

  grant_t             expected_grants [$];
  int                 err_count = 0;
  bit                 no_idle = 1'b0;
  int                 hold_seq = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;
  int                 stuck_cycles = 0;
  logic [TICK_W-1:0]  tick_now = '0;

  frame_table_lru_evict_core #(.FRAMES(FRAMES)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .page_id(page_id), .frame_num(frame_num),
    .frame_given(frame_given), .now_tick(now_tick),
    .out_valid(out_valid), .out_ready(out_ready),
    .granted_frame(granted_frame), .evicted(evicted),
    .victim_page(victim_page), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int find_earliest(logic [FRAME_W-1:0] f);
    int best;
    best = -1;
    for (int i = 0; i < FRAMES; i++) begin
      if (tbl_valid[i] && tbl_frame[i] == f && (best < 0 || tbl_rank[i] < tbl_rank[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic void close_gap(int unsigned rank);
    for (int i = 0; i < FRAMES; i++)
      if (tbl_valid[i] && tbl_rank[i] > rank) tbl_rank[i]--;
  endfunction

  function automatic grant_t predict_table_op(beat_t b);
    grant_t r;
    int     k;
    r = '0;
    r.status = ST_OK;
    case (b.action)
      ACT_ALLOC: begin
        if (b.given) begin
          for (k = 0; k < FRAMES && tbl_valid[k]; k++) begin end
          if (tbl_count >= FRAMES || k >= FRAMES) begin
            r.status = ST_FULL;
          end else begin
            tbl_valid[k] = 1'b1;
            tbl_frame[k] = b.frame;
            tbl_page[k]  = b.page;
            tbl_tick[k]  = b.tick;
            tbl_rank[k]  = tbl_count;
            tbl_count++;
            r.frame = b.frame;
          end
        end else begin
          k = -1;
          for (int i = 0; i < FRAMES; i++) begin
            if (tbl_valid[i] && (k < 0 || tbl_tick[i] < tbl_tick[k] ||
                (tbl_tick[i] == tbl_tick[k] && tbl_rank[i] < tbl_rank[k])))
              k = i;
          end
          if (k < 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.victim  = tbl_page[k];
            r.evicted = 1'b1;
            r.frame   = tbl_frame[k];
            close_gap(tbl_rank[k]);
            tbl_rank[k] = tbl_count - 1;
            tbl_page[k] = b.page;
            tbl_tick[k] = b.tick;
          end
        end
      end
      ACT_FREE: begin
        k = find_earliest(b.frame);
        if (k < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          tbl_valid[k] = 1'b0;
          close_gap(tbl_rank[k]);
          tbl_count--;
        end
      end
      ACT_ACCESS: begin
        k = find_earliest(b.frame);
        if (k < 0) r.status = ST_NOTFOUND;
        else tbl_tick[k] = b.tick;
      end
      default: begin end
    endcase
    return r;
  endfunction

  function automatic logic [FRAME_W-1:0] pick_table_frame();
    int start;
    if (tbl_count == 0) return FRAME_W'($urandom_range(31));
    start = $urandom_range(FRAMES - 1);
    for (int i = 0; i < FRAMES; i++)
      if (tbl_valid[(start + i) % FRAMES]) return tbl_frame[(start + i) % FRAMES];
    return '0;
  endfunction

  // mostly slowly rising ticks so ties happen; some wild values
  function automatic logic [TICK_W-1:0] next_tick();
    int r;
    r = $urandom_range(99);
    if (r < 2) tick_now = $urandom;
    else if (r < 92) tick_now = tick_now + $urandom_range(3);
    else return $urandom;
    return tick_now;
  endfunction

  function automatic beat_t rand_beat(int alloc_pct);
    beat_t b;
    int    r;
    b.page   = $urandom;
    b.given  = 1'($urandom_range(1));
    b.frame  = FRAME_W'($urandom);
    b.tick   = next_tick();
    b.action = ACT_UNUSED;
    r = $urandom_range(99);
    if (r < 3) begin
      b.action = ACT_UNUSED;
    end else if (r < 3 + alloc_pct) begin
      b.action = ACT_ALLOC;
      b.given  = 1'b1;
      if ($urandom_range(99) < 60) b.frame = FRAME_W'($urandom_range(31));
    end else begin
      case ($urandom_range(2))
        0: begin
          b.action = ACT_ALLOC;
          b.given  = 1'b0;
        end
        1: b.action = ACT_FREE;
        default: b.action = ACT_ACCESS;
      endcase
      if (b.action != ACT_ALLOC && $urandom_range(99) < 80) b.frame = pick_table_frame();
    end
    return b;
  endfunction

  task automatic send_beat(beat_t b);
    grant_t g;
    while (!no_idle && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= b.action;
    page_id     <= b.page;
    frame_num   <= b.frame;
    frame_given <= b.given;
    now_tick    <= b.tick;
    do @(posedge clk); while (in_ready !== 1'b1);
    g = predict_table_op(b);
    expected_grants.push_back(g);
  endtask

  task automatic send_fields(logic [1:0] act, logic [PAGE_W-1:0] pg, logic [FRAME_W-1:0] fr,
                             logic gv, logic [TICK_W-1:0] tk);
    beat_t b;
    b.action = act;
    b.page   = pg;
    b.frame  = fr;
    b.given  = gv;
    b.tick   = tk;
    send_beat(b);
  endtask

  task automatic test_empty_table_and_unused();
    send_fields(ACT_ALLOC, 32'h0000_0001, 20'h0, 1'b0, 32'd0);
    send_fields(ACT_FREE, '1, '1, 1'b1, '1);
    send_fields(ACT_ACCESS, '0, '0, 1'b0, '0);
    send_fields(ACT_UNUSED, '1, '1, 1'b1, '1);
    send_fields(ACT_UNUSED, '0, '0, 1'b0, '0);
  endtask

  task automatic test_extremes_and_ties();
    send_fields(ACT_ALLOC, '0, '0, 1'b1, '0);
    send_fields(ACT_ALLOC, '1, '1, 1'b1, '1);
    send_fields(ACT_ALLOC, 32'ha5a5_a5a5, 20'h12345, 1'b1, 32'd5);
    send_fields(ACT_ALLOC, 32'h5a5a_5a5a, 20'h12345, 1'b1, 32'd5);
    send_fields(ACT_ACCESS, '0, '1, 1'b0, 32'd0);
    send_fields(ACT_ALLOC, 32'd1, 20'h00abc, 1'b0, 32'd5);
    send_fields(ACT_ALLOC, 32'd2, '0, 1'b0, 32'd7);
    send_fields(ACT_ALLOC, 32'd3, '1, 1'b0, 32'd7);
    send_fields(ACT_ACCESS, '1, 20'h12345, 1'b1, '1);
    send_fields(ACT_FREE, '0, 20'h12345, 1'b0, '0);
    send_fields(ACT_FREE, '0, 20'h12345, 1'b1, '0);
    send_fields(ACT_FREE, '0, 20'h12345, 1'b0, '0);
    send_fields(ACT_ACCESS, '0, '0, 1'b0, 32'h8000_0000);
    send_fields(ACT_ACCESS, '0, 20'h00777, 1'b0, 32'd9);
    send_fields(ACT_ALLOC, 32'hdead_beef, '0, 1'b0, '1);
    send_fields(ACT_FREE, '1, '0, 1'b1, '1);
    send_fields(ACT_FREE, '0, '1, 1'b0, '0);
    send_fields(ACT_FREE, '0, '1, 1'b0, '0);
  endtask

  task automatic test_fill_to_full();
    beat_t b;
    while (tbl_count < FRAMES) begin
      b = rand_beat(100);
      b.action = ACT_ALLOC;
      b.given  = 1'b1;
      send_beat(b);
    end
    repeat (3) begin
      b = rand_beat(100);
      b.action = ACT_ALLOC;
      b.given  = 1'b1;
      send_beat(b);
    end
    repeat (20) send_beat(rand_beat(30));
    while (tbl_count > 0) begin
      b = rand_beat(0);
      b.action = ACT_FREE;
      b.frame  = pick_table_frame();
      send_beat(b);
    end
  endtask

  task automatic test_random_mix(int n, int alloc_pct);
    repeat (n) send_beat(rand_beat(alloc_pct));
  endtask

  task automatic test_output_hold();
    hold_seq++;
    repeat (20) send_beat(rand_beat(40));
  endtask

  task automatic test_no_idle_burst();
    no_idle = 1'b1;
    test_random_mix(300, 40);
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    grant_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_grants.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected result beat: frame %h evicted %b victim %h status %0d",
                   granted_frame, evicted, victim_page, status);
      end else begin
        e = expected_grants.pop_front();
        if (granted_frame !== e.frame || evicted !== e.evicted ||
            victim_page !== e.victim || status !== e.status) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("mismatch: frame %h/%h evicted %b/%b victim %h/%h status %0d/%0d (act/exp)",
                     granted_frame, e.frame, evicted, e.evicted,
                     victim_page, e.victim, status, e.status);
        end
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 36);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    tbl_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_table_and_unused();
    test_extremes_and_ties();
    test_fill_to_full();
    test_random_mix(400, 60);
    test_random_mix(400, 25);
    test_output_hold();
    test_no_idle_burst();
    test_random_mix(400, 45);
    test_random_mix(250, 15);
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_grants.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ftle_pkg.sv
rtl/ftle_store.sv
rtl/ftle_cmp.sv
rtl/frame_table_lru_evict_core.sv
tb/frame_table_lru_evict_core_test.sv
